// File: rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// shared types and constants of the 3d gauss-seidel poisson solver
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int VAL_W = 32;
    localparam int RES_W = 63;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    localparam logic [1:0] CFG_GRID  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TOL   = 2'd2;
    localparam logic [1:0] CFG_H2    = 2'd3;

    localparam logic [RES_W-1:0] RES_MAX  = {RES_W{1'b1}};
    localparam logic [32:0]      SQ_LIMIT = 33'd3037000499;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REPLY,
        S_CHK,
        S_RD,
        S_MUL,
        S_RND,
        S_TOT,
        S_DIV,
        S_WB,
        S_SQ,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        operation;
        logic [5:0]        coord_x;
        logic [5:0]        coord_y;
        logic [5:0]        coord_z;
        logic signed [31:0] potential_in;
        logic signed [31:0] source_in;
    } t_in;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] potential_out;
        logic [15:0]        sweeps_done;
        logic [62:0]        residual_out;
    } t_out;

endpackage

// File: rtl/gauss_seidel_poisson_3d_solver.sv
// write point: stored on the transfer; read point: memory data and then the
// result are registered; solve: states S_RD to S_ACC per point, S_CHK per sweep,
// paced by the seven reads on the single potential port and the reciprocal divide
// only one item is in work at a time; the input is ready only when idle
// reset clears control state and loads register defaults; grid memories
// are not cleared and hold undefined data until written
// ----------------------------------------------------------------------------
// gauss_seidel_poisson_3d_solver
// memory based 7-point gauss-seidel solver for a 3d poisson grid
// ----------------------------------------------------------------------------
module gauss_seidel_poisson_3d_solver import gsp_pkg::*; #(
    parameter int MAX_GRID = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data
);

    localparam int SIDE   = MAX_GRID + 2;
    localparam int PDEPTH = SIDE * SIDE * SIDE;
    localparam int SDEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int PA_W   = $clog2(PDEPTH);
    localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CW     = $clog2(SIDE);

    function automatic logic [PA_W-1:0] f_paddr(input int x, input int y, input int z);
        return PA_W'((x * SIDE + y) * SIDE + z);
    endfunction

    function automatic logic [SA_W-1:0] f_saddr(input int x, input int y, input int z);
        return SA_W'(((x - 1) * MAX_GRID + (y - 1)) * MAX_GRID + (z - 1));
    endfunction

    t_state r_state, n_state;

    logic [5:0]  r_grid;
    logic [15:0] r_limit;
    logic [62:0] r_tol;
    logic [18:0] r_h2;

    logic signed [31:0] pot_mem [PDEPTH];
    logic signed [31:0] src_mem [SDEPTH];
    logic signed [31:0] r_pot_q;
    logic signed [31:0] r_src_q;

    logic [CW-1:0] r_x, r_y, r_z, r_n;
    logic [2:0]    r_rd_cnt;
    logic [15:0]   r_k;
    logic [62:0]   r_acc;
    logic          r_inside;

    logic signed [31:0] r_old;
    logic signed [34:0] r_sum;
    logic signed [50:0] r_prod;
    logic signed [35:0] r_hq;
    logic               r_tneg;
    logic [32:0]        r_dmag;
    logic [62:0]        r_sq;

    logic        r_out_valid;
    t_out        r_out;

    logic              in_xfer, out_free;
    logic              in_grid, interior;
    logic [PA_W-1:0]   port_pa, ca, nb_pa, pot_raddr, pot_waddr;
    logic [SA_W-1:0]   port_sa, cur_sa;
    logic              pot_re, pot_we, src_we;
    logic signed [31:0] pot_wdata, nv;
    logic [50:0]        mag_p;
    logic [34:0]        q35;
    logic signed [35:0] hq;
    logic signed [36:0] t;
    logic [35:0]        tmag;
    logic               div_start, div_done;
    logic [35:0]        div_q;
    logic signed [32:0] d;
    logic [63:0]        acc_sum;
    logic [63:0]        sq_full;
    logic               run_sweep, last_pt;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign in_grid = (int'(i_in_data.coord_x) <= MAX_GRID + 1) &&
                     (int'(i_in_data.coord_y) <= MAX_GRID + 1) &&
                     (int'(i_in_data.coord_z) <= MAX_GRID + 1);
    assign interior = in_grid &&
                      (i_in_data.coord_x != 6'd0) && (int'(i_in_data.coord_x) <= MAX_GRID) &&
                      (i_in_data.coord_y != 6'd0) && (int'(i_in_data.coord_y) <= MAX_GRID) &&
                      (i_in_data.coord_z != 6'd0) && (int'(i_in_data.coord_z) <= MAX_GRID);

    assign port_pa = f_paddr(int'(i_in_data.coord_x), int'(i_in_data.coord_y),
                             int'(i_in_data.coord_z));
    assign port_sa = f_saddr(int'(i_in_data.coord_x), int'(i_in_data.coord_y),
                             int'(i_in_data.coord_z));
    assign ca      = f_paddr(int'(r_x), int'(r_y), int'(r_z));
    assign cur_sa  = f_saddr(int'(r_x), int'(r_y), int'(r_z));

    // neighbour order: center, x-, x+, y-, y+, z-, z+
    always_comb begin
        case (r_rd_cnt)
            3'd1:    nb_pa = ca - PA_W'(SIDE * SIDE);
            3'd2:    nb_pa = ca + PA_W'(SIDE * SIDE);
            3'd3:    nb_pa = ca - PA_W'(SIDE);
            3'd4:    nb_pa = ca + PA_W'(SIDE);
            3'd5:    nb_pa = ca - PA_W'(1);
            3'd6:    nb_pa = ca + PA_W'(1);
            default: nb_pa = ca;
        endcase
    end

    assign pot_re    = (r_state == S_RD && r_rd_cnt != 3'd7) ||
                       (in_xfer && i_in_data.operation == OP_READ && in_grid);
    assign pot_raddr = (r_state == S_RD) ? nb_pa : port_pa;
    assign pot_we    = (r_state == S_WB) ||
                       (in_xfer && i_in_data.operation == OP_WRITE && in_grid);
    assign pot_waddr = (r_state == S_WB) ? ca : port_pa;
    assign pot_wdata = (r_state == S_WB) ? nv : i_in_data.potential_in;
    assign src_we    = in_xfer && i_in_data.operation == OP_WRITE && interior;

    always_ff @(posedge i_clk) begin
        if (pot_we) begin
            pot_mem[pot_waddr] <= pot_wdata;
        end
        if (pot_re) begin
            r_pot_q <= pot_mem[pot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            src_mem[port_sa] <= i_in_data.source_in;
        end
        if (r_state == S_RD && r_rd_cnt == 3'd0) begin
            r_src_q <= src_mem[cur_sa];
        end
    end

    // update arithmetic
    always_comb begin
        mag_p = r_prod[50] ? 51'(-r_prod) : 51'(r_prod);
        q35   = 35'((mag_p + 51'd32768) >> 16);
        hq    = r_prod[50] ? -$signed({1'b0, q35}) : $signed({1'b0, q35});
        t     = 37'(r_sum) + 37'(r_hq);
        tmag  = 36'(t[36] ? -t : t) + 36'd3;
        if (r_tneg) begin
            nv = (div_q > 36'h080000000) ? 32'sh80000000 : 32'(36'd0 - div_q);
        end else begin
            nv = (div_q > 36'h07FFFFFFF) ? 32'sh7FFFFFFF : div_q[31:0];
        end
        d       = 33'(nv) - 33'(r_old);
        acc_sum = {1'b0, r_acc} + {1'b0, r_sq};
        sq_full = {32'd0, r_dmag[31:0]} * {32'd0, r_dmag[31:0]};
    end

    assign div_start = (r_state == S_TOT);

    gsp_div6 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (tmag),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign run_sweep = (r_k < r_limit) && (r_acc > r_tol);
    assign last_pt   = (r_x == r_n) && (r_y == r_n) && (r_z == r_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.operation)
                        OP_READ:  n_state = S_REPLY;
                        OP_SOLVE: n_state = S_CHK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_REPLY: if (out_free) n_state = S_IDLE;
            S_CHK: begin
                if (!run_sweep) begin
                    n_state = S_DONE;
                end else if (r_n != '0) begin
                    n_state = S_RD;
                end
            end
            S_RD:  if (r_rd_cnt == 3'd7) n_state = S_MUL;
            S_MUL: n_state = S_RND;
            S_RND: n_state = S_TOT;
            S_TOT: n_state = S_DIV;
            S_DIV: if (div_done) n_state = S_WB;
            S_WB:  n_state = S_SQ;
            S_SQ:  n_state = S_ACC;
            S_ACC: n_state = last_pt ? S_CHK : S_RD;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= 6'd8;
            r_limit <= 16'd1000;
            r_tol   <= 63'd65536;
            r_h2    <= 19'd3236;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID:  r_grid  <= i_cfg_data[5:0];
                CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                CFG_TOL:   r_tol   <= i_cfg_data;
                CFG_H2:    r_h2    <= i_cfg_data[18:0];
                default:   r_grid  <= r_grid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_acc       <= '0;
            r_rd_cnt    <= '0;
        end else begin
            if ((r_state == S_REPLY || r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_in_data.operation == OP_SOLVE) begin
                        r_k   <= '0;
                        r_acc <= (r_tol == RES_MAX) ? RES_MAX : r_tol + 63'd1;
                    end
                end
                S_CHK: begin
                    if (run_sweep) begin
                        r_acc    <= '0;
                        r_rd_cnt <= '0;
                        if (r_n == '0) begin
                            r_k <= r_k + 16'd1;
                        end
                    end
                end
                S_RD: begin
                    r_rd_cnt <= r_rd_cnt + 3'd1;
                end
                S_ACC: begin
                    r_acc    <= (acc_sum > {1'b0, RES_MAX}) ? RES_MAX : acc_sum[62:0];
                    r_rd_cnt <= '0;
                    if (last_pt) begin
                        r_k <= r_k + 16'd1;
                    end
                end
                default: r_rd_cnt <= r_rd_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_inside <= in_grid;
                r_n      <= (int'(r_grid) > MAX_GRID) ? CW'(MAX_GRID) : CW'(r_grid);
            end
            S_REPLY: begin
                if (out_free) begin
                    r_out.result_kind   <= KIND_READ;
                    r_out.potential_out <= r_inside ? r_pot_q : '0;
                    r_out.sweeps_done   <= '0;
                    r_out.residual_out  <= '0;
                end
            end
            S_CHK: begin
                r_x <= CW'(1);
                r_y <= CW'(1);
                r_z <= CW'(1);
            end
            S_RD: begin
                if (r_rd_cnt == 3'd0) begin
                    r_sum <= '0;
                end else if (r_rd_cnt == 3'd1) begin
                    r_old <= r_pot_q;
                end else begin
                    r_sum <= r_sum + 35'(r_pot_q);
                end
            end
            S_MUL: r_prod <= $signed({1'b0, r_h2}) * r_src_q;
            S_RND: r_hq   <= hq;
            S_TOT: r_tneg <= t[36];
            S_WB:  r_dmag <= d[32] ? 33'(-d) : 33'(d);
            S_SQ: begin
                r_sq <= (r_dmag > SQ_LIMIT) ? RES_MAX : sq_full[62:0];
            end
            S_ACC: begin
                if (r_z != r_n) begin
                    r_z <= r_z + CW'(1);
                end else begin
                    r_z <= CW'(1);
                    if (r_y != r_n) begin
                        r_y <= r_y + CW'(1);
                    end else begin
                        r_y <= CW'(1);
                        r_x <= r_x + CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.result_kind   <= KIND_SOLVE;
                    r_out.potential_out <= '0;
                    r_out.sweeps_done   <= r_k;
                    r_out.residual_out  <= r_acc;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/gsp_div6.sv
// ----------------------------------------------------------------------------
// gsp_div6
// divide by six through a reciprocal multiply split into low and high partial products
// ----------------------------------------------------------------------------
module gsp_div6 import gsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [35:0] i_dividend,
    output logic        o_done,
    output logic [35:0] o_quotient
);

    // floor(n / 6) = floor(n * ((2^37 + 1) / 3) / 2^38) for n below 2^36
    localparam logic [17:0] DIV_RL = 18'h2AAAB;
    localparam logic [17:0] DIV_RH = 18'h2AAAA;

    logic [35:0] r_num;
    logic [71:0] r_prod;
    logic        r_lo;
    logic        r_hi;
    logic        r_done;
    logic [53:0] pp_lo, pp_hi;

    assign pp_lo = {18'd0, r_num} * {36'd0, DIV_RL};
    assign pp_hi = {18'd0, r_num} * {36'd0, DIV_RH};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo   <= 1'b0;
            r_hi   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_lo   <= i_start;
            r_hi   <= r_lo;
            r_done <= r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
        end
        if (r_lo) begin
            r_prod <= {18'd0, pp_lo};
        end else if (r_hi) begin
            r_prod <= r_prod + {pp_hi, 18'd0};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = {2'b00, r_prod[71:38]};

endmodule

// File: rtl/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker
// port level checks of the poisson solver, bound to the top level
// ----------------------------------------------------------------------------
module gsp_checker import gsp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in         i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out        o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_READ |->
        o_out_data.sweeps_done == '0 && o_out_data.residual_out == '0)
        else $error("read result carries solve fields");

    a_solve_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_SOLVE |->
        o_out_data.potential_out == '0)
        else $error("solve result carries a potential");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_in_data.operation == OP_SOLVE || i_in_data.operation == OP_READ)
        |=> !o_in_ready)
        else $error("input ready while a transfer is in work");

endmodule

bind gauss_seidel_poisson_3d_solver gsp_checker u_gsp_checker (.*);
